// ----- rtl/core/rgbm_pkg.sv -----
// Package for the RGB LED mode controller.
// Holds the shared constants, state codes and the stage structs.
// No dependencies.
package rgbm_pkg;

  localparam logic [16:0] DELAY_STEP  = 17'd1000;
  localparam logic [16:0] DELAY_MIN   = 17'd1000;
  localparam logic [16:0] DELAY_MAX   = 17'd100000;
  localparam logic [16:0] MANUAL_WAIT = 17'd100000;
  localparam logic [7:0]  HOLD_LIMIT  = 8'd150;
  localparam logic [7:0]  LONG_HOLD   = 8'd100;
  localparam logic [7:0]  LEVEL_LOW   = 8'd2;
  localparam logic [7:0]  LEVEL_HIGH  = 8'd254;
  localparam logic [7:0]  NUDGE_MIN   = 8'd20;
  localparam logic [15:0] PWM_LOAD_RESET = 16'd11362;

  // floor(x / 125) == (x * RECIP_125) >> RECIP_SHIFT for every x below 2**21.
  localparam logic [21:0] RECIP_125   = 22'd2147484;
  localparam int          RECIP_SHIFT = 28;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [1:0] {
    MODE_AUTO  = 2'd0,
    MODE_RED   = 2'd1,
    MODE_BLUE  = 2'd2,
    MODE_GREEN = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    DEB_IDLE  = 2'd0,
    DEB_ARMED = 2'd1,
    DEB_HELD  = 2'd2
  } deb_t;

  typedef enum logic [1:0] {
    PH_RG = 2'd0,
    PH_GB = 2'd1,
    PH_BR = 2'd2
  } phase_t;

  typedef struct packed {
    mode_t       mode;
    logic [16:0] step_wait;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } levels_t;

  typedef struct packed {
    levels_t     lv;
    logic [14:0] red_width;
    logic [14:0] green_width;
    logic [14:0] blue_width;
  } result_t;

endpackage

// ----- rtl/core/rgbm_ctrl.sv -----
// Button debouncers, mode selection and colour stepping for the controller.
// Updates the state on each accepted beat and shows the post-beat snapshot.
// Depends on rgbm_pkg.
module rgbm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              command,
  input  logic              down_pressed,
  input  logic              up_pressed,
  output rgbm_pkg::levels_t snap
);

  rgbm_pkg::deb_t   down_state, down_state_next;
  rgbm_pkg::deb_t   up_state, up_state_next;
  logic [7:0]       press_count, press_count_next;
  logic [7:0]       hold_count, hold_count_next;
  logic             down_held, down_held_next;
  rgbm_pkg::mode_t  mode, mode_next;
  logic [16:0]      fade_delay, fade_delay_next;
  rgbm_pkg::phase_t phase, phase_next;
  logic [7:0]       red, red_next;
  logic [7:0]       green, green_next;
  logic [7:0]       blue, blue_next;

  function automatic logic [7:0] nudge(input logic [7:0] v, input logic dn, input logic up);
    logic [7:0] r;
    r = v;
    if (dn) begin
      r = r - 8'd1;
      if (r < rgbm_pkg::NUDGE_MIN) r = rgbm_pkg::NUDGE_MIN;
    end
    if (up) begin
      r = r + 8'd1;
      if (r > rgbm_pkg::LEVEL_HIGH) r = rgbm_pkg::LEVEL_HIGH;
    end
    return r;
  endfunction

  always_comb begin
    down_state_next  = down_state;
    up_state_next    = up_state;
    press_count_next = press_count;
    hold_count_next  = hold_count;
    down_held_next   = down_held;
    mode_next        = mode;
    fade_delay_next  = fade_delay;
    phase_next       = phase;
    red_next         = red;
    green_next       = green;
    blue_next        = blue;
    if (accept) begin
      if (command == rgbm_pkg::CMD_TICK) begin
        if (down_pressed) begin
          if (down_state == rgbm_pkg::DEB_ARMED) begin
            down_state_next = rgbm_pkg::DEB_HELD;
            down_held_next  = 1'b1;
            if (hold_count > rgbm_pkg::LONG_HOLD) begin
              press_count_next = press_count + 8'd1;
            end else begin
              press_count_next = 8'd0;
            end
            if (fade_delay < rgbm_pkg::DELAY_MIN + rgbm_pkg::DELAY_STEP) begin
              fade_delay_next = rgbm_pkg::DELAY_MIN;
            end else begin
              fade_delay_next = fade_delay - rgbm_pkg::DELAY_STEP;
            end
          end else if (down_state != rgbm_pkg::DEB_HELD) begin
            down_state_next = rgbm_pkg::DEB_ARMED;
          end
        end else begin
          if (down_state == rgbm_pkg::DEB_HELD) down_held_next = 1'b0;
          down_state_next = rgbm_pkg::DEB_IDLE;
        end

        if (up_pressed) begin
          case (up_state)
            rgbm_pkg::DEB_ARMED: begin
              up_state_next = rgbm_pkg::DEB_HELD;
              if (fade_delay_next + rgbm_pkg::DELAY_STEP > rgbm_pkg::DELAY_MAX) begin
                fade_delay_next = rgbm_pkg::DELAY_MAX;
              end else begin
                fade_delay_next = fade_delay_next + rgbm_pkg::DELAY_STEP;
              end
            end
            rgbm_pkg::DEB_HELD: begin
              if (hold_count < rgbm_pkg::HOLD_LIMIT) hold_count_next = hold_count + 8'd1;
            end
            default: begin
              up_state_next = rgbm_pkg::DEB_ARMED;
            end
          endcase
        end else begin
          if (up_state == rgbm_pkg::DEB_HELD) begin
            hold_count_next  = 8'd0;
            press_count_next = 8'd0;
          end
          up_state_next = rgbm_pkg::DEB_IDLE;
        end

        if (hold_count_next > rgbm_pkg::LONG_HOLD) begin
          if (press_count_next == 8'd1) begin
            mode_next = rgbm_pkg::MODE_RED;
          end else if (press_count_next == 8'd2) begin
            mode_next = rgbm_pkg::MODE_BLUE;
          end else if (press_count_next == 8'd0 && down_held_next) begin
            mode_next = rgbm_pkg::MODE_GREEN;
          end
        end
      end else begin
        case (mode)
          rgbm_pkg::MODE_AUTO: begin
            case (phase)
              rgbm_pkg::PH_RG: begin
                red_next   = red - 8'd1;
                green_next = green + 8'd1;
                if (red_next == rgbm_pkg::LEVEL_LOW && green_next == rgbm_pkg::LEVEL_HIGH) begin
                  phase_next = rgbm_pkg::PH_GB;
                end
              end
              rgbm_pkg::PH_GB: begin
                green_next = green - 8'd1;
                blue_next  = blue + 8'd1;
                if (green_next == rgbm_pkg::LEVEL_LOW && blue_next == rgbm_pkg::LEVEL_HIGH) begin
                  phase_next = rgbm_pkg::PH_BR;
                end
              end
              rgbm_pkg::PH_BR: begin
                blue_next = blue - 8'd1;
                red_next  = red + 8'd1;
                if (blue_next == rgbm_pkg::LEVEL_LOW && red_next == rgbm_pkg::LEVEL_HIGH) begin
                  phase_next = rgbm_pkg::PH_RG;
                end
              end
              default: begin
                phase_next = phase;
              end
            endcase
          end
          rgbm_pkg::MODE_RED: begin
            blue_next  = rgbm_pkg::LEVEL_LOW;
            green_next = rgbm_pkg::LEVEL_LOW;
            red_next   = nudge(red, down_pressed, up_pressed);
          end
          rgbm_pkg::MODE_BLUE: begin
            red_next   = rgbm_pkg::LEVEL_LOW;
            green_next = rgbm_pkg::LEVEL_LOW;
            blue_next  = nudge(blue, down_pressed, up_pressed);
          end
          default: begin
            blue_next  = rgbm_pkg::LEVEL_LOW;
            red_next   = rgbm_pkg::LEVEL_LOW;
            green_next = nudge(green, down_pressed, up_pressed);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down_state  <= rgbm_pkg::DEB_IDLE;
      up_state    <= rgbm_pkg::DEB_IDLE;
      press_count <= 8'd0;
      hold_count  <= 8'd0;
      down_held   <= 1'b0;
      mode        <= rgbm_pkg::MODE_AUTO;
      fade_delay  <= rgbm_pkg::DELAY_MAX;
      phase       <= rgbm_pkg::PH_RG;
      red         <= rgbm_pkg::LEVEL_HIGH;
      green       <= rgbm_pkg::LEVEL_LOW;
      blue        <= rgbm_pkg::LEVEL_LOW;
    end else begin
      down_state  <= down_state_next;
      up_state    <= up_state_next;
      press_count <= press_count_next;
      hold_count  <= hold_count_next;
      down_held   <= down_held_next;
      mode        <= mode_next;
      fade_delay  <= fade_delay_next;
      phase       <= phase_next;
      red         <= red_next;
      green       <= green_next;
      blue        <= blue_next;
    end
  end

  always_comb begin
    snap.mode      = mode_next;
    snap.step_wait = (mode_next == rgbm_pkg::MODE_AUTO) ? fade_delay_next
                                                        : rgbm_pkg::MANUAL_WAIT;
    snap.red       = red_next;
    snap.green     = green_next;
    snap.blue      = blue_next;
  end

endmodule

// ----- rtl/core/rgbm_scale.sv -----
// Two-stage pulse width scaler: level times PWM load, then divide by 1000.
// The divide is a shift by three and a reciprocal multiply by 1/125.
// Depends on rgbm_pkg.
module rgbm_scale (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rgbm_pkg::levels_t in_lv,
  input  logic [15:0]       load,
  output logic              out_valid,
  input  logic              out_ready,
  output rgbm_pkg::result_t out_res
);

  logic              prod_valid;
  logic              prod_ready;
  rgbm_pkg::levels_t prod_lv;
  logic [23:0]       red_prod;
  logic [23:0]       green_prod;
  logic [23:0]       blue_prod;

  function automatic logic [14:0] div1000(input logic [23:0] p);
    logic [42:0] full;
    full = 43'(p[23:3]) * 43'(rgbm_pkg::RECIP_125);
    return full[rgbm_pkg::RECIP_SHIFT +: 15];
  endfunction

  assign prod_ready = !out_valid || out_ready;
  assign in_ready   = !prod_valid || prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) prod_valid <= in_valid;
      if (prod_ready) out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod_lv    <= in_lv;
      red_prod   <= 24'(in_lv.red) * 24'(load);
      green_prod <= 24'(in_lv.green) * 24'(load);
      blue_prod  <= 24'(in_lv.blue) * 24'(load);
    end
    if (prod_ready && prod_valid) begin
      out_res.lv          <= prod_lv;
      out_res.red_width   <= div1000(red_prod);
      out_res.green_width <= div1000(green_prod);
      out_res.blue_width  <= div1000(blue_prod);
    end
  end

endmodule

// ----- rtl/core/rgb_led_mode_controller.sv -----
// Top level of the RGB LED mode controller.
// Instantiates rgbm_ctrl and rgbm_scale; depends on rgbm_pkg.
//
// Each input beat on the s_ side is a debounce tick (s_tuser low) or a colour
// step (s_tuser high), with the two button levels in s_tdata. Every beat
// yields exactly one result beat on the m_ side with the mode, the wait before
// the next step, the three levels and the three pulse widths.
// The controller state is updated in the cycle a beat is accepted; the
// snapshot then passes a stage register, the product register and the output
// register, which holds the result beat until it is taken on the m_ side.
// One beat is taken every cycle while results are drained; the rate is set
// by the single state update per cycle in rgbm_ctrl.
// When m_tready is low, results fill the three stages and s_tready drops only
// once all three hold a result. cfg_data loads the PWM period whenever
// cfg_valid is high; it should only change while no beat is in flight.
// Reset is synchronous: the state returns to auto fade with red at 254, the
// fade delay at 100000, the PWM period at 11362 and all stages empty.
module rgb_led_mode_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // down_button_pressed, up_button_pressed, zeros
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  // current_mode, step_wait, red_level, green_level, blue_level,
  // red_width, green_width, blue_width
  output logic [87:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic              accept;
  logic              stage_valid;
  logic              stage_ready;
  logic              scale_ready;
  logic [15:0]       pwm_load;
  rgbm_pkg::levels_t snap;
  rgbm_pkg::levels_t stage_lv;
  rgbm_pkg::result_t res;

  assign cfg_ready   = 1'b1;
  assign stage_ready = !stage_valid || scale_ready;
  assign s_tready    = stage_ready;
  assign accept      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_load    <= rgbm_pkg::PWM_LOAD_RESET;
      stage_valid <= 1'b0;
    end else begin
      if (cfg_valid) pwm_load <= cfg_data;
      if (stage_ready) stage_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) stage_lv <= snap;
  end

  rgbm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .command      (s_tuser),
    .down_pressed (s_tdata[0]),
    .up_pressed   (s_tdata[1]),
    .snap         (snap)
  );

  rgbm_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid),
    .in_ready  (scale_ready),
    .in_lv     (stage_lv),
    .load      (pwm_load),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {res.blue_width, res.green_width, res.red_width,
                    res.lv.blue, res.lv.green, res.lv.red,
                    res.lv.step_wait, res.lv.mode};

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && stage_valid))
    else $error("input stalled while a stage was free");

  a_manual_wait: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.lv.mode != rgbm_pkg::MODE_AUTO) |->
      (res.lv.step_wait == rgbm_pkg::MANUAL_WAIT))
    else $error("manual mode result with wrong wait");

  a_auto_wait_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.lv.mode == rgbm_pkg::MODE_AUTO) |->
      (res.lv.step_wait >= rgbm_pkg::DELAY_MIN && res.lv.step_wait <= rgbm_pkg::DELAY_MAX))
    else $error("fade delay out of range");

  a_zero_level_width: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.lv.red == 8'd0) |-> (res.red_width == 15'd0))
    else $error("nonzero width for a dark channel");

endmodule

// ----- bench/rgbm_led_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the RGB LED mode controller bench: watches the input,
// result and PWM period channels, models the controller and compares beats.
// Depends on rgbm_pkg for the mode, debounce and fade phase codes.
module rgbm_led_checker
  import rgbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [87:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          pending,
  output int          fail_count,
  output int          result_count,
  output logic [3:0]  modes_seen
);

  // Fields are declared from the top of the result beat down, so that a cast
  // of m_tdata lands the mode in the lowest bits.
  typedef struct packed {
    logic [14:0] blue_w;
    logic [14:0] green_w;
    logic [14:0] red_w;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [16:0] step_wait;
    mode_t       mode;
  } led_beat_t;

  led_beat_t   expected_leds[$];

  logic [15:0] pwm_load;
  deb_t        dn_deb;
  deb_t        up_deb;
  logic [7:0]  press_cnt;
  logic [7:0]  hold_cnt;
  logic        dn_flag;
  mode_t       mode;
  logic [16:0] fade_delay;
  phase_t      fade_ph;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  function automatic logic [7:0] nudge_level(logic [7:0] v, logic dn, logic up);
    logic [7:0] n;
    n = v;
    if (dn) begin
      n = n - 8'd1;
      if (n < NUDGE_MIN) n = NUDGE_MIN;
    end
    if (up) begin
      n = n + 8'd1;
      if (n > LEVEL_HIGH) n = LEVEL_HIGH;
    end
    return n;
  endfunction

  function automatic logic [14:0] pulse_width(logic [7:0] lvl);
    logic [31:0] p;
    p = (32'(lvl) * 32'(pwm_load)) / 32'd1000;
    return p[14:0];
  endfunction

  function automatic led_beat_t advance_controller(logic cmd, logic dn, logic up);
    led_beat_t r;
    if (cmd == CMD_TICK) begin
      // The down debouncer sees the hold count before the up debouncer moves it.
      if (dn) begin
        if (dn_deb == DEB_ARMED) begin
          dn_deb = DEB_HELD;
          dn_flag = 1'b1;
          if (hold_cnt > LONG_HOLD) press_cnt = press_cnt + 8'd1;
          else press_cnt = 8'd0;
          if (fade_delay < DELAY_MIN + DELAY_STEP) fade_delay = DELAY_MIN;
          else fade_delay = fade_delay - DELAY_STEP;
        end else if (dn_deb != DEB_HELD) begin
          dn_deb = DEB_ARMED;
        end
      end else begin
        if (dn_deb == DEB_HELD) dn_flag = 1'b0;
        dn_deb = DEB_IDLE;
      end
      if (up) begin
        if (up_deb == DEB_ARMED) begin
          up_deb = DEB_HELD;
          fade_delay = fade_delay + DELAY_STEP;
          if (fade_delay > DELAY_MAX) fade_delay = DELAY_MAX;
        end else if (up_deb == DEB_HELD) begin
          if (hold_cnt < HOLD_LIMIT) hold_cnt = hold_cnt + 8'd1;
        end else begin
          up_deb = DEB_ARMED;
        end
      end else begin
        if (up_deb == DEB_HELD) begin
          hold_cnt = 8'd0;
          press_cnt = 8'd0;
        end
        up_deb = DEB_IDLE;
      end
      if (hold_cnt > LONG_HOLD) begin
        if (press_cnt == 8'd1) mode = MODE_RED;
        else if (press_cnt == 8'd2) mode = MODE_BLUE;
        else if (press_cnt == 8'd0 && dn_flag) mode = MODE_GREEN;
      end
    end else begin
      case (mode)
        MODE_AUTO: begin
          case (fade_ph)
            PH_RG: begin
              red = red - 8'd1;
              green = green + 8'd1;
              if (red == LEVEL_LOW && green == LEVEL_HIGH) fade_ph = PH_GB;
            end
            PH_GB: begin
              green = green - 8'd1;
              blue = blue + 8'd1;
              if (green == LEVEL_LOW && blue == LEVEL_HIGH) fade_ph = PH_BR;
            end
            PH_BR: begin
              blue = blue - 8'd1;
              red = red + 8'd1;
              if (blue == LEVEL_LOW && red == LEVEL_HIGH) fade_ph = PH_RG;
            end
            default: ;
          endcase
        end
        MODE_RED: begin
          blue = LEVEL_LOW;
          green = LEVEL_LOW;
          red = nudge_level(red, dn, up);
        end
        MODE_BLUE: begin
          red = LEVEL_LOW;
          green = LEVEL_LOW;
          blue = nudge_level(blue, dn, up);
        end
        default: begin
          blue = LEVEL_LOW;
          red = LEVEL_LOW;
          green = nudge_level(green, dn, up);
        end
      endcase
    end
    r.mode = mode;
    r.step_wait = (mode == MODE_AUTO) ? fade_delay : MANUAL_WAIT;
    r.red = red;
    r.green = green;
    r.blue = blue;
    r.red_w = pulse_width(red);
    r.green_w = pulse_width(green);
    r.blue_w = pulse_width(blue);
    return r;
  endfunction

  function automatic void check_field(string name, int got, int want);
    if (got != want) begin
      if (fail_count < 10)
        $display("%s mismatch on result %0d: expected %0d, got %0d",
                 name, result_count, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    led_beat_t got;
    led_beat_t want;
    if (rst) begin
      expected_leds.delete();
      pwm_load = PWM_LOAD_RESET;
      dn_deb = DEB_IDLE;
      up_deb = DEB_IDLE;
      press_cnt = 8'd0;
      hold_cnt = 8'd0;
      dn_flag = 1'b0;
      mode = MODE_AUTO;
      fade_delay = DELAY_MAX;
      fade_ph = PH_RG;
      red = LEVEL_HIGH;
      green = LEVEL_LOW;
      blue = LEVEL_LOW;
      fail_count = 0;
      result_count = 0;
      modes_seen = '0;
    end else begin
      if (cfg_valid && cfg_ready) pwm_load = cfg_data;
      if (m_tvalid && m_tready) begin
        got = led_beat_t'(m_tdata);
        if (expected_leds.size() == 0) begin
          if (fail_count < 10)
            $display("Result beat %0d arrived with nothing expected.", result_count);
          fail_count++;
        end else begin
          want = expected_leds.pop_front();
          modes_seen[want.mode] = 1'b1;
          check_field("current_mode", int'(got.mode), int'(want.mode));
          check_field("step_wait", int'(got.step_wait), int'(want.step_wait));
          check_field("red_level", int'(got.red), int'(want.red));
          check_field("green_level", int'(got.green), int'(want.green));
          check_field("blue_level", int'(got.blue), int'(want.blue));
          check_field("red_width", int'(got.red_w), int'(want.red_w));
          check_field("green_width", int'(got.green_w), int'(want.green_w));
          check_field("blue_width", int'(got.blue_w), int'(want.blue_w));
        end
        result_count++;
      end
      if (s_tvalid && s_tready)
        expected_leds.push_back(advance_controller(s_tuser, s_tdata[0], s_tdata[1]));
    end
    pending <= expected_leds.size();
  end

endmodule

// ----- bench/tb_rgb_led_mode_controller.sv -----
`timescale 1ns / 1ps
// Top of the RGB LED mode controller bench: clock, reset, stimulus, stalls
// and the verdict. Depends on rgb_led_mode_controller, rgbm_led_checker, rgbm_pkg.
module tb_rgb_led_mode_controller;
  import rgbm_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // down_button_pressed, up_button_pressed, zeros
  logic        s_tuser;   // command
  logic        m_tvalid;
  logic        m_tready;
  // current_mode, step_wait, red_level, green_level, blue_level,
  // red_width, green_width, blue_width
  logic [87:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  int          pending;
  int          fail_count;
  int          result_count;
  logic [3:0]  modes_seen;

  logic        calm = 1'b0;
  int          n_ticks = 0;
  int          n_steps = 0;
  int          n_fade = 0;
  int          n_down = 0;
  int          n_up = 0;
  int          n_loads = 0;

  always #5 clk = ~clk;

  rgb_led_mode_controller u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  rgbm_led_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .pending      (pending),
    .fail_count   (fail_count),
    .result_count (result_count),
    .modes_seen   (modes_seen)
  );

  task automatic send_beat(input logic cmd, input logic dn, input logic up);
    if (!calm && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {6'b0, up, dn};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (cmd == CMD_STEP) n_steps++;
    else n_ticks++;
  endtask

  task automatic colour_burst(input int n, input int dn_pct, input int up_pct);
    logic dn;
    logic up;
    repeat (n) begin
      dn = ($urandom_range(0, 99) < dn_pct);
      up = ($urandom_range(0, 99) < up_pct);
      send_beat(CMD_STEP, dn, up);
    end
  endtask

  task automatic down_press(input logic up_lvl, input int extra);
    send_beat(CMD_TICK, 1'b1, up_lvl);
    send_beat(CMD_TICK, 1'b1, up_lvl);
    repeat (extra) send_beat(CMD_TICK, 1'b1, up_lvl);
    send_beat(CMD_TICK, 1'b0, up_lvl);
  endtask

  task automatic up_press(input int extra);
    send_beat(CMD_TICK, 1'b0, 1'b1);
    send_beat(CMD_TICK, 1'b0, 1'b1);
    repeat (extra) send_beat(CMD_TICK, 1'b0, 1'b1);
    send_beat(CMD_TICK, 1'b0, 1'b0);
  endtask

  task automatic noise(input int n);
    repeat (n) send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
    send_beat(CMD_TICK, 1'b0, 1'b0);
  endtask

  // Down is held through the start of a long up hold, which selects manual
  // green; after its release, one and then two presses select red and blue.
  task automatic manual_tour(input int hold_len);
    send_beat(CMD_TICK, 1'b1, 1'b0);
    send_beat(CMD_TICK, 1'b1, 1'b0);
    repeat (hold_len) begin
      send_beat(CMD_TICK, 1'b1, 1'b1);
      if ($urandom_range(0, 19) == 0) colour_burst($urandom_range(1, 3), 50, 50);
    end
    colour_burst($urandom_range(10, 20), 60, 30);
    send_beat(CMD_TICK, 1'b0, 1'b1);
    down_press(1'b1, $urandom_range(0, 1));
    colour_burst($urandom_range(10, 20), 30, 60);
    down_press(1'b1, $urandom_range(0, 1));
    colour_burst($urandom_range(10, 20), 50, 50);
    down_press(1'b1, 0);
    send_beat(CMD_TICK, 1'b0, 1'b0);
    colour_burst($urandom_range(10, 20), 50, 50);
  endtask

  task automatic fade_mix(input int fade_goal, input int down_goal);
    int pick;
    int k;
    while (n_fade < fade_goal || n_down < n_up + down_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 50 && n_down < n_up + down_goal) begin
        down_press(1'b0, ($urandom_range(0, 7) == 0) ? 1 : 0);
        n_down++;
      end else if (pick < 94 && n_fade < fade_goal) begin
        k = $urandom_range(5, 30);
        colour_burst(k, 50, 50);
        n_fade += k;
      end else if (pick >= 97) begin
        up_press($urandom_range(0, 2));
        n_up++;
      end else if (pick >= 94) begin
        noise($urandom_range(1, 3));
      end
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_load(input logic [15:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_loads++;
  endtask

  initial begin
    forever begin
      m_tready <= 1'b1;
      if (calm || $urandom_range(0, 3) == 0) repeat ($urandom_range(30, 120)) @(posedge clk);
      else repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!calm) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser <= CMD_TICK;
    s_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed opening at the largest PWM period: fade steps with buttons
    // ignored, an up press at the delay ceiling, presses of each button and both.
    write_load(16'hFFFF);
    send_beat(CMD_STEP, 1'b0, 1'b0);
    send_beat(CMD_STEP, 1'b1, 1'b1);
    up_press(1);
    down_press(1'b0, 1);
    send_beat(CMD_TICK, 1'b1, 1'b1);
    send_beat(CMD_TICK, 1'b1, 1'b1);
    send_beat(CMD_TICK, 1'b1, 1'b1);
    send_beat(CMD_TICK, 1'b0, 1'b0);
    send_beat(CMD_STEP, 1'b1, 1'b0);
    send_beat(CMD_STEP, 1'b0, 1'b1);

    // Auto fade into its third phase while the delay is driven to its floor.
    write_load(16'h0000);
    fade_mix(260, 52);
    write_load(16'($urandom_range(1, 65534)));
    fade_mix(520, 105);

    // Manual modes in one long up hold that reaches the hold count cap.
    write_load(16'($urandom_range(0, 65535)));
    manual_tour(152);

    write_load(PWM_LOAD_RESET);
    calm <= 1'b1;
    colour_burst(30, 50, 50);
    noise(4);

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d ticks and %0d colour steps under %0d PWM periods; %0d results checked.",
             n_ticks, n_steps, n_loads, result_count);
    $display("Modes reached, one bit per mode: %b.", modes_seen);
    if (pending != 0) $display("%0d results never arrived.", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding.", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/rgbm_pkg.sv
rtl/core/rgbm_ctrl.sv
rtl/core/rgbm_scale.sv
rtl/core/rgb_led_mode_controller.sv
bench/rgbm_led_checker.sv
bench/tb_rgb_led_mode_controller.sv
